>>> rtl/core/uts_pkg.sv
// ----------------------------------------------------------------------------
// uts_pkg
// Shared types and constants for the UART word serializer.
// ----------------------------------------------------------------------------
package uts_pkg;

  // Bytes held by one loaded word
  localparam int unsigned WORD_BYTES    = 4;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned BCNT_W        = 3;
  localparam int unsigned PEND_W        = 6;
  localparam int unsigned SLOT_W        = 17;
  localparam int unsigned DIV_W         = 16;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CHAR_BITS_MIN = 5;

  // Item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Frame phases
  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_PARITY = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_BITS_SEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BIT_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TX_ENABLE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_DIVIDER  = 3'd4;

  // Line configuration
  typedef struct packed {
    logic [1:0]       char_bits_sel;
    logic             parity_enable;
    logic [1:0]       stop_bit_count;
    logic             tx_enable;
    logic [DIV_W-1:0] clock_divider;
  } uts_cfg_t;

  // One result word
  typedef struct packed {
    logic line;
    logic bit_sent;
    logic word_done;
    logic load_accepted;
    logic busy_res;
  } uts_res_t;

endpackage

>>> rtl/core/uts_frame_engine.sv
// ----------------------------------------------------------------------------
// uts_frame_engine
// Frame state and slot timer; computes one result per accepted word.
// ----------------------------------------------------------------------------
module uts_frame_engine
  import uts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              op,
  input  logic [WORD_W-1:0] word,
  input  logic [BCNT_W-1:0] byte_count,
  input  uts_cfg_t          cfg,
  output uts_res_t          res_nxt
);

  logic [1:0]        phase_r, phase_nxt;
  logic [WORD_W-1:0] shift_r, shift_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [3:0]        cbits_r, cbits_nxt;
  logic              par_r, par_nxt;
  logic [1:0]        stops_r, stops_nxt;
  logic [SLOT_W-1:0] wait_r, wait_nxt;
  logic              line_r, line_nxt;

  logic [BCNT_W-1:0] n_sat;
  logic [3:0]        cbits_inc;
  logic [3:0]        char_len;
  logic [1:0]        stop_load;
  logic              active;
  logic              tx_bit;
  logic              sent, done, taken;

  assign n_sat     = (byte_count > BCNT_W'(WORD_BYTES)) ? BCNT_W'(WORD_BYTES) : byte_count;
  assign cbits_inc = cbits_r + 4'd1;
  assign char_len  = {2'b00, cfg.char_bits_sel} + 4'(CHAR_BITS_MIN);
  assign stop_load = (cfg.stop_bit_count == 2'd0) ? 2'd1 : cfg.stop_bit_count;
  assign active    = (pend_r != '0) || (phase_r == PH_PARITY) || (phase_r == PH_STOP);

  // Next-state logic for one word
  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    pend_nxt  = pend_r;
    cbits_nxt = cbits_r;
    par_nxt   = par_r;
    stops_nxt = stops_r;
    wait_nxt  = wait_r;
    line_nxt  = line_r;
    tx_bit    = 1'b1;
    sent      = 1'b0;
    done      = 1'b0;
    taken     = 1'b0;

    if (op == OP_LOAD) begin
      if ((pend_r == '0) && (byte_count != '0)) begin
        shift_nxt = word;
        pend_nxt  = {n_sat, 3'b000};
        taken     = 1'b1;
      end
    end else if (wait_r != '0) begin
      wait_nxt = wait_r - SLOT_W'(1);
    end else if (active) begin
      unique case (phase_r)
        PH_START: begin
          par_nxt   = 1'b0;
          phase_nxt = PH_DATA;
          tx_bit    = 1'b0;
        end
        PH_DATA: begin
          tx_bit    = shift_r[0];
          shift_nxt = {1'b0, shift_r[WORD_W-1:1]};
          pend_nxt  = pend_r - PEND_W'(1);
          par_nxt   = par_r ^ shift_r[0];
          cbits_nxt = cbits_inc;
          done      = (pend_r == PEND_W'(1));
          // character complete: parity or stop bits next
          if (cbits_inc >= char_len) begin
            cbits_nxt = 4'd0;
            if (cfg.parity_enable) begin
              phase_nxt = PH_PARITY;
            end else begin
              phase_nxt = PH_STOP;
              stops_nxt = stop_load;
            end
          end
        end
        PH_PARITY: begin
          tx_bit    = par_r;
          phase_nxt = PH_STOP;
          stops_nxt = stop_load;
        end
        PH_STOP: begin
          tx_bit    = 1'b1;
          stops_nxt = stops_r - 2'd1;
          if (stops_r == 2'd1) begin
            phase_nxt = PH_START;
          end
        end
        default: begin
          tx_bit = 1'b1;
        end
      endcase

      // drive the line and restart the slot timer
      if (cfg.tx_enable) begin
        line_nxt = tx_bit;
        sent     = 1'b1;
        wait_nxt = {1'b0, cfg.clock_divider} + SLOT_W'(1);
      end
    end
  end

  always_comb begin
    res_nxt.line          = line_nxt;
    res_nxt.bit_sent      = sent;
    res_nxt.word_done     = done;
    res_nxt.load_accepted = taken;
    res_nxt.busy_res      = (pend_nxt != '0);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      shift_r <= '0;
      pend_r  <= '0;
      cbits_r <= '0;
      par_r   <= 1'b0;
      stops_r <= '0;
      wait_r  <= '0;
      line_r  <= 1'b1;
    end else if (accept) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      pend_r  <= pend_nxt;
      cbits_r <= cbits_nxt;
      par_r   <= par_nxt;
      stops_r <= stops_nxt;
      wait_r  <= wait_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

>>> rtl/core/uart_tx_word_serializer.sv
// ----------------------------------------------------------------------------
// uart_tx_word_serializer
// UART transmitter fed with load and tick words; one result word per input.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake              Payload
//  in_      in   in_valid / in_ready    in_op, in_word, in_byte_count
//  out_     out  out_valid / out_ready  out_line, out_bit_sent, out_word_done,
//                                       out_load_accepted, out_busy_res
//  cfg_     in   cfg_we (no wait)       cfg_index, cfg_wdata
//
//  One word per cycle unless out_ready stalls: state updates on acceptance,
//  the result lands in the output register on the next edge. A word is taken
//  while the output register is empty or being drained, so a stalled out_ready
//  holds in_ready low only while a result waits. Reset (sync, rst_n low) puts
//  the engine's line state idle high and loads the configuration defaults.
// ----------------------------------------------------------------------------
module uart_tx_word_serializer
  import uts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [WORD_W-1:0]    in_word,
  input  logic [BCNT_W-1:0]    in_byte_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_line,
  output logic                 out_bit_sent,
  output logic                 out_word_done,
  output logic                 out_load_accepted,
  output logic                 out_busy_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIV_W-1:0]     cfg_wdata
);

  uts_cfg_t cfg_r;
  uts_res_t res_nxt;
  uts_res_t res_r;
  logic     out_valid_r;
  logic     accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.char_bits_sel  <= 2'd3;
      cfg_r.parity_enable  <= 1'b0;
      cfg_r.stop_bit_count <= 2'd1;
      cfg_r.tx_enable      <= 1'b1;
      cfg_r.clock_divider  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHAR_BITS_SEL:  cfg_r.char_bits_sel  <= cfg_wdata[1:0];
        REG_PARITY_ENABLE:  cfg_r.parity_enable  <= cfg_wdata[0];
        REG_STOP_BIT_COUNT: cfg_r.stop_bit_count <= cfg_wdata[1:0];
        REG_TX_ENABLE:      cfg_r.tx_enable      <= cfg_wdata[0];
        REG_CLOCK_DIVIDER:  cfg_r.clock_divider  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  uts_frame_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .op         (in_op),
    .word       (in_word),
    .byte_count (in_byte_count),
    .cfg        (cfg_r),
    .res_nxt    (res_nxt)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line          = res_r.line;
  assign out_bit_sent      = res_r.bit_sent;
  assign out_word_done     = res_r.word_done;
  assign out_load_accepted = res_r.load_accepted;
  assign out_busy_res      = res_r.busy_res;

endmodule
